// File: src/kvt_pkg.sv
// Shared types, codes and helper functions for the key/value table.
`default_nettype none

package kvt_pkg;

   // Default sizing of the table
   localparam int DEPTH_DEF     = 128;
   localparam int KEY_CHARS_DEF = 8;

   // Fixed field widths of the request and response channels
   localparam int OP_W      = 2;
   localparam int WORD_W    = 64;
   localparam int STATUS_W  = 2;
   localparam int IDX_OUT_W = 7;
   localparam int CNT_OUT_W = 8;
   localparam int WORD_CHARS = WORD_W / 8;

   // One table entry is a key and a value side by side
   localparam int ENTRY_W = 2 * WORD_W;

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR  = 2'd0,
      OP_INSERT = 2'd1,
      OP_DELETE = 2'd2,
      OP_LOOKUP = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK   = 2'd0,
      STAT_MISS = 2'd1,
      STAT_FULL = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_MOVE_RD,
      ST_MOVE_WR,
      ST_APPEND,
      ST_FINISH
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load_req;    // capture the request and clear the result
      logic clear_count; // empty the table
      logic scan_start;  // restart the search at slot zero
      logic scan_step;   // issue the next search read
      logic hit;         // remember the matched slot
      logic found;       // return the matched slot and its value
      logic set_miss;    // report key not found
      logic set_full;    // report table full
      logic move_rd;     // shrink the count and read the last entry
      logic move_wr;     // copy the last entry into the matched slot
      logic append;      // write the pair at the end and grow the count
      logic load_rsp;    // hand the result to the response register
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      op_type op;
      logic   match;     // the entry under compare holds the key
      logic   exhausted; // every used entry has been compared
      logic   full;      // every slot is in use
      logic   out_free;  // the response register can take a result
   } sts_type;

   // Keep at most nchars characters and stop at the first zero byte
   function automatic logic [WORD_W-1:0] canon(input logic [WORD_W-1:0] s,
                                               input int nchars);
      logic [WORD_W-1:0] r;
      logic              alive;
      r     = '0;
      alive = 1'b1;
      for (int i = 0; i < WORD_CHARS; i++) begin
         if (i >= nchars || s[8*i +: 8] == 8'h00) begin
            alive = 1'b0;
         end
         if (alive) begin
            r[8*i +: 8] = s[8*i +: 8];
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: src/kvt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module kvt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: src/kvt_ctrl.sv
// Controller state machine that sequences search, move and append steps.
`default_nettype none

module kvt_ctrl
   import kvt_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (sts.op == OP_CLEAR) begin
               cmd.clear_count = 1'b1;
               state_in        = ST_FINISH;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sts.match) begin
               cmd.hit = 1'b1;
               if (sts.op == OP_LOOKUP) begin
                  cmd.found = 1'b1;
                  state_in  = ST_FINISH;
               end else begin
                  state_in = ST_MOVE_RD;
               end
            end else if (sts.exhausted) begin
               if (sts.op == OP_INSERT) begin
                  if (sts.full) begin
                     cmd.set_full = 1'b1;
                     state_in     = ST_FINISH;
                  end else begin
                     state_in = ST_APPEND;
                  end
               end else begin
                  cmd.set_miss = 1'b1;
                  state_in     = ST_FINISH;
               end
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_MOVE_RD: begin
            cmd.move_rd = 1'b1;
            state_in    = ST_MOVE_WR;
         end
         ST_MOVE_WR: begin
            cmd.move_wr = 1'b1;
            if (sts.op == OP_INSERT) begin
               state_in = ST_APPEND;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_APPEND: begin
            cmd.append = 1'b1;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: src/kvt_dp.sv
// Datapath: request registers, entry RAM, search pointer, count and response register.
`default_nettype none

module kvt_dp
   import kvt_pkg::*;
#(
   parameter int DEPTH     = DEPTH_DEF,
   parameter int KEY_CHARS = KEY_CHARS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [OP_W-1:0]      req_operation,
   input  wire logic [WORD_W-1:0]    req_key,
   input  wire logic [WORD_W-1:0]    req_value,
   input  wire cmd_type              cmd,
   output sts_type                   sts,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic [IDX_OUT_W-1:0]      rsp_entry_index,
   output logic [WORD_W-1:0]         rsp_found_value,
   output logic [CNT_OUT_W-1:0]      rsp_entry_count
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   // Request registers
   op_type            op_ff;
   logic [WORD_W-1:0] key_ff;
   logic [WORD_W-1:0] value_ff;

   // Table occupancy and search state
   logic [CW-1:0] count_ff;
   logic [CW-1:0] ptr_ff;
   logic          cmp_vld_ff;
   logic [AW-1:0] cmp_idx_ff;
   logic [AW-1:0] hit_idx_ff;

   // Working result
   status_type        res_status_ff;
   logic [AW-1:0]     res_index_ff;
   logic [WORD_W-1:0] res_fval_ff;

   // Response register
   logic                 rsp_valid_ff;
   status_type           rsp_status_ff;
   logic [IDX_OUT_W-1:0] rsp_index_ff;
   logic [WORD_W-1:0]    rsp_fval_ff;
   logic [CNT_OUT_W-1:0] rsp_count_ff;

   // RAM ports
   logic               ram_wr_en;
   logic [AW-1:0]      ram_wr_addr;
   logic [ENTRY_W-1:0] ram_wr_data;
   logic               ram_rd_en;
   logic [AW-1:0]      ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rd_data;
   logic [WORD_W-1:0]  rd_key;
   logic [WORD_W-1:0]  rd_value;

   logic                    more;
   logic [CW-1:0]           count_dec;
   logic [AW+IDX_OUT_W-1:0] idx_wide;
   logic [CW+CNT_OUT_W-1:0] cnt_wide;

   assign rd_key    = ram_rd_data[ENTRY_W-1:WORD_W];
   assign rd_value  = ram_rd_data[WORD_W-1:0];
   assign more      = ptr_ff < count_ff;
   assign count_dec = count_ff - 1'b1;

   // Route reads and writes of the entry RAM
   assign ram_rd_en   = (cmd.scan_step && more) || cmd.move_rd;
   assign ram_rd_addr = cmd.move_rd ? count_dec[AW-1:0] : ptr_ff[AW-1:0];
   assign ram_wr_en   = cmd.move_wr || cmd.append;
   assign ram_wr_addr = cmd.move_wr ? hit_idx_ff : count_ff[AW-1:0];
   assign ram_wr_data = cmd.move_wr ? ram_rd_data : {key_ff, value_ff};

   kvt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Status toward the controller
   assign sts.op        = op_ff;
   assign sts.match     = cmp_vld_ff && (rd_key == key_ff);
   assign sts.exhausted = !cmp_vld_ff && !more;
   assign sts.full      = count_ff == CW'(DEPTH);
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;

   // Capture the request, keys and values cut at their string end
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff    <= op_type'(req_operation);
         key_ff   <= canon(req_key, KEY_CHARS);
         value_ff <= canon(req_value, WORD_CHARS);
      end
   end

   // Track the number of used entries
   always_ff @(posedge clock) begin
      if (reset || cmd.clear_count) begin
         count_ff <= '0;
      end else if (cmd.move_rd) begin
         count_ff <= count_dec;
      end else if (cmd.append) begin
         count_ff <= count_ff + 1'b1;
      end
   end

   // Walk the used entries, one read issued per step
   always_ff @(posedge clock) begin
      if (reset || cmd.scan_start) begin
         ptr_ff     <= '0;
         cmp_vld_ff <= 1'b0;
      end else if (cmd.scan_step) begin
         cmp_vld_ff <= more;
         if (more) begin
            ptr_ff <= ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_step) begin
         cmp_idx_ff <= ptr_ff[AW-1:0];
      end
      if (cmd.hit) begin
         hit_idx_ff <= cmp_idx_ff;
      end
   end

   // Build the result of the current request
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         res_status_ff <= STAT_OK;
         res_index_ff  <= '0;
         res_fval_ff   <= '0;
      end else begin
         if (cmd.found) begin
            res_index_ff <= cmp_idx_ff;
            res_fval_ff  <= rd_value;
         end
         if (cmd.append) begin
            res_index_ff <= count_ff[AW-1:0];
         end
         if (cmd.set_miss) begin
            res_status_ff <= STAT_MISS;
         end
         if (cmd.set_full) begin
            res_status_ff <= STAT_FULL;
         end
      end
   end

   // Mask index and count to the response widths
   assign idx_wide = {{IDX_OUT_W{1'b0}}, res_index_ff};
   assign cnt_wide = {{CNT_OUT_W{1'b0}}, count_ff};

   // Response register: hold until the transfer completes
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_index_ff  <= idx_wide[IDX_OUT_W-1:0];
         rsp_fval_ff   <= res_fval_ff;
         rsp_count_ff  <= cnt_wide[CNT_OUT_W-1:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_index = rsp_index_ff;
   assign rsp_found_value = rsp_fval_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

`default_nettype wire

// File: src/key_value_table.sv
// Top level of the key/value table: controller, datapath and checks.
// Clear skips the search; insert, delete and lookup run a linear search that
// reads one entry per cycle through the single read port of the entry RAM.
// Throughput: one request at a time; the next is accepted once the result is in
// the response register. Reset empties the table; stored entries are not cleared.
`default_nettype none

module key_value_table
   import kvt_pkg::*;
#(
   parameter int DEPTH     = DEPTH_DEF,
   parameter int KEY_CHARS = KEY_CHARS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [OP_W-1:0]      req_operation,
   input  wire logic [WORD_W-1:0]    req_key,
   input  wire logic [WORD_W-1:0]    req_value,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic [IDX_OUT_W-1:0]      rsp_entry_index,
   output logic [WORD_W-1:0]         rsp_found_value,
   output logic [CNT_OUT_W-1:0]      rsp_entry_count
);

   cmd_type cmd;
   sts_type sts;

   kvt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   kvt_dp #(
      .DEPTH     (DEPTH),
      .KEY_CHARS (KEY_CHARS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_operation   (req_operation),
      .req_key         (req_key),
      .req_value       (req_value),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_entry_index (rsp_entry_index),
      .rsp_found_value (rsp_found_value),
      .rsp_entry_count (rsp_entry_count)
   );

   // A request being worked on blocks the next one
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while the previous one is in progress");

   // Never append into a full table
   a_no_append_when_full: assert property (@(posedge clock) disable iff (reset)
      cmd.append |-> !sts.full)
      else $error("append issued with every slot in use");

   // A refused insert returns no slot and no value
   a_full_result_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_FULL |->
         rsp_entry_index == '0 && rsp_found_value == '0)
      else $error("table full result carries an index or a value");

   // A found value comes only with a found status
   a_value_only_on_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_OK |-> rsp_found_value == '0)
      else $error("value returned on a miss");

endmodule

`default_nettype wire
